/* rtl/core/hba_pkg.sv */
package hba_pkg;

	// defaults for the top-level parameters
	localparam int MAX_HANDLES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int SLOT_BYTES_DEF   = 4;

	// field widths
	localparam int OP_W     = 3;
	localparam int ETYPE_W  = 3;
	localparam int COUNT_W  = 32;
	localparam int CLASS_W  = 16;
	localparam int HNDL_W   = 12;
	localparam int STATUS_W = 3;
	localparam int OFFS_W   = 24;
	localparam int WORDS_W  = 23;
	localparam int ALEN_W   = 25;
	localparam int HEAP_W   = 25;

	// size arithmetic: product of a 31-bit count and at most 8 bytes, plus
	// length word, header and rounding
	localparam int PROD_W  = 34;
	localparam int PAYLD_W = 35;
	localparam int TOTAL_W = 36;
	localparam int SUM_W   = TOTAL_W + 1;

	localparam logic [HEAP_W-1:0] HEAP_CAP   = 25'd16777216;
	localparam logic [HEAP_W-1:0] HEAP_RESET = 25'd1048576;

	localparam logic [TOTAL_W-1:0] ALIGN_LOW  = 36'd7;
	localparam logic [TOTAL_W-1:0] ALIGN_MASK = ~ALIGN_LOW;
	localparam logic [PAYLD_W-1:0] LEN_WORD_BYTES = 35'd4;

	// request codes
	localparam logic [OP_W-1:0] OP_OBJECT    = 3'd0;
	localparam logic [OP_W-1:0] OP_PRIM_ARR  = 3'd1;
	localparam logic [OP_W-1:0] OP_REF_ARR   = 3'd2;
	localparam logic [OP_W-1:0] OP_LONG_ARR  = 3'd3;
	localparam logic [OP_W-1:0] OP_RELEASE   = 3'd4;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEMORY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NEG_LENGTH = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [WORDS_W-1:0] words;
		logic [ALEN_W-1:0]  arr_len;
	} size_info_t;

endpackage

/* rtl/core/hba_ram.sv */
module hba_ram import hba_pkg::*; #(
	parameter int DEPTH = MAX_HANDLES_DEF,
	parameter int WIDTH = HNDL_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/hba_size.sv */
module hba_size import hba_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int SLOT_BYTES   = SLOT_BYTES_DEF
) (
	input  logic [OP_W-1:0]    op,
	input  logic [ETYPE_W-1:0] elem_type,
	input  logic [COUNT_W-1:0] count,
	output size_info_t         size
);

	logic [PROD_W-1:0]  cnt_ext;
	logic [PROD_W-1:0]  slot_prod;
	logic [PROD_W-1:0]  prod;
	logic [PAYLD_W-1:0] payload;
	logic [TOTAL_W-1:0] pay_round;
	logic [TOTAL_W-1:0] total;

	// sign bit is checked elsewhere; only the magnitude matters here
	assign cnt_ext   = PROD_W'(count[COUNT_W-2:0]);
	assign slot_prod = cnt_ext * PROD_W'(SLOT_BYTES);

	always_comb begin
		case (op)
			OP_PRIM_ARR: prod = cnt_ext << elem_type[2:1];
			OP_LONG_ARR: prod = cnt_ext << 3;
			default:     prod = slot_prod;
		endcase
	end

	always_comb begin
		if (op == OP_OBJECT) begin
			payload = PAYLD_W'(prod);
		end else begin
			payload = PAYLD_W'(prod) + LEN_WORD_BYTES;
		end
	end

	assign pay_round = (TOTAL_W'(payload) + ALIGN_LOW) & ALIGN_MASK;
	assign total     = (TOTAL_W'(payload) + TOTAL_W'(HEADER_BYTES) + ALIGN_LOW) & ALIGN_MASK;

	always_comb begin
		size.total = total;
		if (op == OP_OBJECT) begin
			size.words   = count[WORDS_W-1:0];
			size.arr_len = '0;
		end else begin
			size.words   = pay_round[WORDS_W+1:2];
			size.arr_len = count[ALEN_W-1:0];
		end
	end

endmodule

/* rtl/core/heap_bump_allocator_with_handles.sv */
// The transfer cycle sizes the request and issues the free-stack and live-bit reads; the
// second stage then compares against the heap limit, picks the handle and writes back.
// A new request is taken only once the previous one has left the second stage; a
// result left waiting holds the next request in the second stage and stalls the input.
// Reset restores heap_size to 1 MiB, clears bump pointer, free count and control and sets
// the fresh index to 1; memories are not cleared, handles at or above the fresh index read as not live.
module heap_bump_allocator_with_handles import hba_pkg::*; #(
	parameter int MAX_HANDLES  = MAX_HANDLES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int SLOT_BYTES   = SLOT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [HEAP_W-1:0] cfg_wdata,     // heap_size
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,  // elem_type, count, class_ref, handle, pad
	input  logic [2:0]        s_axis_tuser,  // operation
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [103:0]      m_axis_tdata,  // new_handle, byte_offset, payload words,
	                                         // array length, header_class, pad
	output logic [2:0]        m_axis_tuser   // status
);

	localparam int HW = $clog2(MAX_HANDLES);

	// request fields
	logic [OP_W-1:0]    in_op;
	logic [ETYPE_W-1:0] in_etype;
	logic [COUNT_W-1:0] in_count;
	logic [CLASS_W-1:0] in_class;
	logic [HNDL_W-1:0]  in_handle;
	size_info_t         in_size;
	logic               in_xfer;

	assign in_op     = s_axis_tuser;
	assign in_etype  = s_axis_tdata[2:0];
	assign in_count  = s_axis_tdata[34:3];
	assign in_class  = s_axis_tdata[50:35];
	assign in_handle = s_axis_tdata[62:51];

	// architectural state
	logic [HEAP_W-1:0] heap_size_q;
	logic [HEAP_W-1:0] bump_q;
	logic [HW:0]       next_fresh_q;
	logic [HW:0]       free_count_q;
	logic              busy_q;

	// first stage
	logic [OP_W-1:0]    op_s1;
	logic               neg_s1;
	size_info_t         size_s1;
	logic [CLASS_W-1:0] class_s1;
	logic [HNDL_W-1:0]  rel_s1;

	// result register
	logic                m_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [HNDL_W-1:0]   new_handle_q;
	logic [OFFS_W-1:0]   offset_q;
	logic [WORDS_W-1:0]  words_q;
	logic [ALEN_W-1:0]   alen_q;
	logic [CLASS_W-1:0]  hclass_q;

	// memories
	logic          stk_we;
	logic [HW-1:0] stk_waddr;
	logic [HW-1:0] stk_wdata;
	logic [HW-1:0] stk_rdata;
	logic          live_we;
	logic [HW-1:0] live_waddr;
	logic          live_wdata;
	logic          live_rdata;

	// second stage
	logic                done;
	logic [HEAP_W-1:0]   limit;
	logic [SUM_W-1:0]    bump_sum;
	logic                fits;
	logic [HW-1:0]       rel_idx;
	logic                rel_live;
	logic                rel_ok;
	logic                alloc_ok;
	logic                use_pop;
	logic [HW-1:0]       alloc_h;
	logic [STATUS_W-1:0] status_d;

	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && !busy_q;
	assign done          = busy_q && (!m_valid_q || m_axis_tready);

	hba_size #(
		.HEADER_BYTES(HEADER_BYTES),
		.SLOT_BYTES  (SLOT_BYTES)
	) u_size (
		.op       (in_op),
		.elem_type(in_etype),
		.count    (in_count),
		.size     (in_size)
	);

	hba_ram #(
		.DEPTH(MAX_HANDLES),
		.WIDTH(HW)
	) u_free_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (in_xfer),
		.raddr(HW'(free_count_q - 1'b1)),
		.rdata(stk_rdata)
	);

	hba_ram #(
		.DEPTH(MAX_HANDLES),
		.WIDTH(1)
	) u_live (
		.clk  (clk),
		.we   (live_we),
		.waddr(live_waddr),
		.wdata(live_wdata),
		.re   (in_xfer),
		.raddr(HW'(in_handle)),
		.rdata(live_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= in_op;
			neg_s1   <= in_count[COUNT_W-1];
			size_s1  <= in_size;
			class_s1 <= in_class;
			rel_s1   <= in_handle;
		end
	end

	assign limit    = (heap_size_q > HEAP_CAP) ? HEAP_CAP : heap_size_q;
	assign bump_sum = SUM_W'(bump_q) + SUM_W'(size_s1.total);
	assign fits     = bump_sum <= SUM_W'(limit);

	// entries at or above the fresh index were never written and read as free
	assign rel_idx  = HW'(rel_s1);
	assign rel_live = live_rdata && ({1'b0, rel_idx} < next_fresh_q);
	assign rel_ok   = (rel_s1 != '0) && ({20'd0, rel_s1} < MAX_HANDLES) && rel_live
		&& (free_count_q < (HW+1)'(MAX_HANDLES));
	assign use_pop  = free_count_q != '0;
	assign alloc_h  = use_pop ? stk_rdata : next_fresh_q[HW-1:0];

	always_comb begin
		alloc_ok = 1'b0;
		case (op_s1) inside
			OP_RELEASE: status_d = rel_ok ? ST_OK : ST_BAD_HANDLE;
			OP_OBJECT, OP_PRIM_ARR, OP_REF_ARR, OP_LONG_ARR: begin
				if (neg_s1) begin
					status_d = ST_NEG_LENGTH;
				end else if (!fits) begin
					status_d = ST_NO_MEMORY;
				end else if (!use_pop && next_fresh_q >= (HW+1)'(MAX_HANDLES)) begin
					status_d = ST_TABLE_FULL;
				end else begin
					status_d = ST_OK;
					alloc_ok = 1'b1;
				end
			end
			default: status_d = ST_BAD_HANDLE;
		endcase
	end

	// release pushes and clears the live bit; allocation sets the live bit
	assign stk_we     = done && (op_s1 == OP_RELEASE) && rel_ok;
	assign stk_waddr  = free_count_q[HW-1:0];
	assign stk_wdata  = rel_idx;
	assign live_we    = stk_we || (done && alloc_ok);
	assign live_waddr = alloc_ok ? alloc_h : rel_idx;
	assign live_wdata = alloc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q  <= HEAP_RESET;
			bump_q       <= '0;
			next_fresh_q <= (HW+1)'(1);
			free_count_q <= '0;
			busy_q       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				heap_size_q <= cfg_wdata;
			end
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (stk_we) begin
				free_count_q <= free_count_q + 1'b1;
			end
			if (done && alloc_ok) begin
				bump_q <= bump_sum[HEAP_W-1:0];
				if (use_pop) begin
					free_count_q <= free_count_q - 1'b1;
				end else begin
					next_fresh_q <= next_fresh_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status_d;
			if (alloc_ok) begin
				new_handle_q <= HNDL_W'(alloc_h);
				offset_q     <= bump_q[OFFS_W-1:0];
				words_q      <= size_s1.words;
				alen_q       <= size_s1.arr_len;
				hclass_q     <= class_s1;
			end else begin
				new_handle_q <= '0;
				offset_q     <= '0;
				words_q      <= '0;
				alen_q       <= '0;
				hclass_q     <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {4'd0, hclass_q, alen_q, words_q, offset_q, new_handle_q};

`ifndef SYNTHESIS
	a_bump_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= HEAP_CAP)
		else $error("bump pointer beyond heap capacity");

	a_free_below_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q < next_fresh_q)
		else $error("more free handles than ever handed out");

	a_no_null_handle: assert property (@(posedge clk) disable iff (!arst_n)
		done && alloc_ok |-> alloc_h != '0)
		else $error("null handle handed out");

	a_fail_keeps_bump: assert property (@(posedge clk) disable iff (!arst_n)
		done && !alloc_ok |=> bump_q == $past(bump_q))
		else $error("failed request moved bump pointer");
`endif

endmodule

/* dv/tb_heap_bump_allocator_with_handles.sv */
module tb_heap_bump_allocator_with_handles;
	timeunit 1ns;
	timeprecision 1ps;

	import hba_pkg::*;

	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [HEAP_W-1:0] HEAP_OVERSIZE = 25'h1FFFFFF;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [ETYPE_W-1:0] elem_type;
		logic [COUNT_W-1:0] count;
		logic [CLASS_W-1:0] class_ref;
		logic [HNDL_W-1:0]  handle;
	} alloc_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [HNDL_W-1:0]   new_handle;
		logic [OFFS_W-1:0]   byte_offset;
		logic [WORDS_W-1:0]  word_count;
		logic [ALEN_W-1:0]   arr_len;
		logic [CLASS_W-1:0]  header_class;
	} alloc_rsp_t;

	// Shadow copy of the heap and handle table; predicts each grant in order.
	class heap_shadow;
		logic [HEAP_W-1:0] heap_limit;
		logic [HEAP_W-1:0] bump;
		logic [HNDL_W:0]   next_fresh;
		logic [HNDL_W:0]   free_cnt;
		logic [HNDL_W-1:0] free_stack [MAX_HANDLES_DEF];
		bit                live [MAX_HANDLES_DEF];
		logic [HNDL_W-1:0] live_q [$];
		alloc_rsp_t        awaited_rsp [$];
		int                errors;
		int                rsp_seen;

		function new();
			heap_limit = HEAP_RESET;
			bump = '0;
			next_fresh = (HNDL_W+1)'(1);
			free_cnt = '0;
			errors = 0;
			rsp_seen = 0;
			foreach (live[i]) live[i] = 1'b0;
		endfunction

		function void accept_request(alloc_req_t r);
			alloc_rsp_t        rsp;
			longint unsigned   cnt, payload, words, total, limit, esz;
			logic [ALEN_W-1:0] alen;
			logic [HNDL_W-1:0] h;
			rsp = '{default: '0};
			h = r.handle;
			alen = '0;
			if (r.op == OP_RELEASE) begin
				if (h == '0 || !live[h] || free_cnt >= MAX_HANDLES_DEF) begin
					rsp.status = ST_BAD_HANDLE;
				end else begin
					live[h] = 1'b0;
					free_stack[free_cnt] = h;
					free_cnt++;
					for (int i = 0; i < live_q.size(); i++) begin
						if (live_q[i] == h) begin
							live_q.delete(i);
							break;
						end
					end
					rsp.status = ST_OK;
				end
			end else if (r.op > OP_RELEASE) begin
				rsp.status = ST_BAD_HANDLE;
			end else if (r.count[COUNT_W-1]) begin
				rsp.status = ST_NEG_LENGTH;
			end else begin
				cnt = 64'(r.count);
				if (r.op == OP_OBJECT) begin
					payload = cnt * SLOT_BYTES_DEF;
					words = cnt;
				end else begin
					if (r.op == OP_PRIM_ARR) esz = 64'd1 << r.elem_type[2:1];
					else if (r.op == OP_REF_ARR) esz = 64'(SLOT_BYTES_DEF);
					else esz = 64'd8;
					payload = 64'd4 + cnt * esz;
					words = ((payload + 64'd7) & ~64'd7) / 64'd4;
					alen = r.count[ALEN_W-1:0];
				end
				total = (64'(HEADER_BYTES_DEF) + payload + 64'd7) & ~64'd7;
				limit = (heap_limit > HEAP_CAP) ? 64'(HEAP_CAP) : 64'(heap_limit);
				if (64'(bump) + total > limit) begin
					rsp.status = ST_NO_MEMORY;
				end else if (free_cnt == 0 && next_fresh >= MAX_HANDLES_DEF) begin
					rsp.status = ST_TABLE_FULL;
				end else begin
					// reuse the most recently freed handle first
					if (free_cnt != 0) begin
						free_cnt--;
						h = free_stack[free_cnt];
					end else begin
						h = next_fresh[HNDL_W-1:0];
						next_fresh++;
					end
					live[h] = 1'b1;
					live_q.insert(live_q.size(), h);
					rsp.status = ST_OK;
					rsp.new_handle = h;
					rsp.byte_offset = bump[OFFS_W-1:0];
					rsp.word_count = words[WORDS_W-1:0];
					rsp.arr_len = alen;
					rsp.header_class = r.class_ref;
					bump = bump + total[HEAP_W-1:0];
				end
			end
			awaited_rsp.insert(awaited_rsp.size(), rsp);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH %s", $realtime, msg);
			errors++;
		endtask

		task compare(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
					rsp_seen, field, got, want));
		endtask

		task check_response(alloc_rsp_t got);
			alloc_rsp_t want;
			if (awaited_rsp.size() == 0) begin
				report($sformatf("result %0d arrived with no request outstanding", rsp_seen));
			end else begin
				want = awaited_rsp.pop_front();
				compare("status", 32'(got.status), 32'(want.status));
				compare("new_handle", 32'(got.new_handle), 32'(want.new_handle));
				compare("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
				compare("word_count", 32'(got.word_count), 32'(want.word_count));
				compare("arr_len", 32'(got.arr_len), 32'(want.arr_len));
				compare("header_class", 32'(got.header_class), 32'(want.header_class));
			end
			rsp_seen++;
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [HEAP_W-1:0]   cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [63:0]         s_axis_tdata = '0;   // elem_type, count, class_ref, handle, pad
	logic [2:0]          s_axis_tuser = '0;   // operation
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [103:0]        m_axis_tdata;        // new_handle, byte_offset, payload words,
	                                          // array length, header_class, pad
	logic [2:0]          m_axis_tuser;        // status

	heap_shadow shadow = new();
	bit         no_idle = 1'b0;
	bit         rx_hold_req = 1'b0;

	always #1 clk = ~clk;

	heap_bump_allocator_with_handles u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic alloc_req_t mk_req(logic [OP_W-1:0] op, logic [ETYPE_W-1:0] et,
		logic [COUNT_W-1:0] cnt, logic [CLASS_W-1:0] cls, logic [HNDL_W-1:0] h);
		alloc_req_t r;
		r.op = op;
		r.elem_type = et;
		r.count = cnt;
		r.class_ref = cls;
		r.handle = h;
		return r;
	endfunction

	function automatic logic [HNDL_W-1:0] pick_live();
		if (shadow.live_q.size() == 0) return '0;
		return shadow.live_q[$urandom_range(0, shadow.live_q.size() - 1)];
	endfunction

	function automatic alloc_req_t rand_request(int release_pct);
		alloc_req_t r;
		int         pick;
		r = mk_req(OP_OBJECT, ETYPE_W'($urandom), '0, CLASS_W'($urandom),
			HNDL_W'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 4) r.count = $urandom | 32'h8000_0000;
		else if (pick < 7) r.count = $urandom;
		else if (pick < 9) r.count = $urandom_range(0, 1 << 20);
		else if (pick < 30) r.count = $urandom_range(0, 300);
		else r.count = $urandom_range(0, 24);
		pick = $urandom_range(0, 99);
		if (pick < release_pct) begin
			r.op = OP_RELEASE;
			pick = $urandom_range(0, 9);
			if (pick < 7 && shadow.live_q.size() != 0) r.handle = pick_live();
			else if (pick == 9) r.handle = '0;
		end else if (pick < release_pct + 3) begin
			r.op = OP_W'($urandom_range(5, 7));
		end else begin
			r.op = OP_W'($urandom_range(0, 3));
		end
		return r;
	endfunction

	// Call at a rising edge; returns at the edge of the transfer.
	task automatic send_request(alloc_req_t r);
		bit ok;
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r.handle, r.class_ref, r.count, r.elem_type};
		s_axis_tuser <= r.op;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		shadow.accept_request(r);
	endtask

	task automatic run_random(int n, int release_pct);
		for (int k = 0; k < n; k++) send_request(rand_request(release_pct));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (shadow.awaited_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_heap(logic [HEAP_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_wdata <= value;
		cfg_wen <= 1'b1;
		@(posedge clk);
		cfg_wen <= 1'b0;
		shadow.heap_limit = value;
	endtask

	// receiver: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// outputs are stable by the falling edge; the transfer completes at the next rise
	always @(negedge clk) begin : rsp_monitor
		alloc_rsp_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.new_handle = m_axis_tdata[11:0];
			got.byte_offset = m_axis_tdata[35:12];
			got.word_count = m_axis_tdata[58:36];
			got.arr_len = m_axis_tdata[83:59];
			got.header_class = m_axis_tdata[99:84];
			shadow.check_response(got);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
			else quiet++;
		end
		$display("** heap_bump_allocator_with_handles: FAILED **");
		$finish;
	end

	initial begin
		int big;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every request kind, each element size, the length, memory and handle error paths
		send_request(mk_req(OP_OBJECT, '0, '0, 16'hFFFF, '0));
		send_request(mk_req(OP_OBJECT, 3'd7, 32'd5, 16'h1234, 12'hFFF));
		for (int t = 0; t < 8; t++)
			send_request(mk_req(OP_PRIM_ARR, ETYPE_W'(t), COUNT_W'(t + 3), CLASS_W'(t), '0));
		send_request(mk_req(OP_REF_ARR, '0, 32'd7, 16'h00AA, '0));
		send_request(mk_req(OP_LONG_ARR, '0, '0, 16'h5500, '0));
		send_request(mk_req(OP_OBJECT, '0, 32'hFFFF_FFFF, 16'h0001, '0));
		send_request(mk_req(OP_PRIM_ARR, 3'd1, 32'h8000_0000, 16'h0002, '0));
		send_request(mk_req(OP_LONG_ARR, '0, 32'h7FFF_FFFF, 16'h0003, '0));
		send_request(mk_req(OP_RELEASE, '0, '0, '0, '0));
		send_request(mk_req(OP_RELEASE, '0, '0, '0, 12'hFFF));
		send_request(mk_req(OP_RELEASE, '0, '0, '0, 12'd2));
		send_request(mk_req(OP_RELEASE, '0, '0, '0, 12'd2));
		send_request(mk_req(OP_OBJECT, 3'd3, 32'd1, 16'h0000, '0));
		send_request(mk_req(3'd5, '0, 32'd1, 16'h0F0F, '0));
		send_request(mk_req(3'd6, '0, '0, '0, 12'd1));
		send_request(mk_req(3'd7, '0, 32'hFFFF_FFFF, '0, '0));

		run_random(150, 20);
		drain();
		run_random(150, 20);

		write_heap('0);
		run_random(40, 20);

		write_heap(shadow.bump + 25'd2048);
		run_random(100, 20);

		// limits above the heap capacity act as the capacity
		write_heap(HEAP_OVERSIZE);
		send_request(mk_req(OP_OBJECT, '0, '0, 16'h7777, '0));
		send_request(mk_req(OP_PRIM_ARR, 3'd6, 32'd9, 16'h8888, '0));
		send_request(mk_req(OP_REF_ARR, '0, 32'h8000_0001, 16'h9999, '0));
		send_request(mk_req(OP_OBJECT, '0, 32'h7FFF_FFFF, 16'hAAAA, '0));

		// an allocation just over and one exactly at the heap limit
		write_heap(shadow.bump);
		send_request(mk_req(OP_OBJECT, '0, '0, 16'hBBBB, '0));
		write_heap(shadow.bump + 25'd16);
		send_request(mk_req(OP_OBJECT, '0, '0, 16'hCCCC, '0));

		write_heap(HEAP_CAP);
		repeat (60) send_request(mk_req(OP_RELEASE, ETYPE_W'($urandom), $urandom,
			CLASS_W'($urandom), pick_live()));
		rx_hold_req = 1'b1;
		run_random(400, 55);

		write_heap(shadow.bump - 25'd8);
		run_random(40, 30);

		write_heap(HEAP_RESET);
		run_random(100, 40);

		write_heap(HEAP_CAP);
		no_idle = 1'b1;
		run_random(300, 40);
		repeat (20) send_request(mk_req(OP_RELEASE, ETYPE_W'($urandom), $urandom,
			CLASS_W'($urandom), pick_live()));
		// push the bump pointer close to the top of the heap
		big = (int'(HEAP_CAP) - int'(shadow.bump) - 2048) / 8;
		send_request(mk_req(OP_LONG_ARR, '0, big, 16'hDEAD, '0));
		repeat (12) send_request(mk_req(OP_OBJECT, '0, $urandom_range(0, 24),
			CLASS_W'($urandom), '0));

		drain();
		repeat (8) @(posedge clk);
		if (shadow.awaited_rsp.size() != 0)
			shadow.report($sformatf("%0d results never arrived", shadow.awaited_rsp.size()));
		if (shadow.errors == 0) begin
			$display("** heap_bump_allocator_with_handles: PASSED **");
		end else begin
			$display("** heap_bump_allocator_with_handles: FAILED **");
		end
		$finish;
	end

endmodule
